[design/compact_to_wide_instruction_expander_defines.svh]
// Assertion macros shared by the checker files of the instruction expander.
`ifndef COMPACT_TO_WIDE_INSTRUCTION_EXPANDER_DEFINES_SVH
`define COMPACT_TO_WIDE_INSTRUCTION_EXPANDER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("expander check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("expander check failed");

`endif

[design/ctw_pkg.sv]
// Package with the translation case table and its types.
package ctw_pkg;

  localparam int unsigned OP_W    = 6;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned WIDE_W  = 32;

  localparam logic [WIDE_W-1:0] UNDEF_WORD = 32'he7ffffff;

  // How the halfword fields are placed into the template.
  typedef enum logic [4:0] {
    K_ALU, K_SHR, K_CMPR, K_NEG, K_MUL, K_MVN,
    K_HADD, K_HCMP, K_HMOV, K_HBX,
    K_DNM, K_W5, K_B5, K_H5, K_SH5,
    K_D8, K_C8, K_A8, K_W8, K_SWI, K_SP7,
    K_PUSH, K_POP, K_STM, K_LDM, K_BC, K_BR, K_NONE
  } kind_t;

  typedef struct packed {
    logic [WIDE_W-1:0] tmpl;
    kind_t             kind;
  } case_def_t;

  localparam case_def_t CASE_TABLE [0:63] = '{
    '{32'he0100000, K_ALU},  '{32'he0300000, K_ALU},  '{32'he1b00010, K_SHR},
    '{32'he1b00030, K_SHR},  '{32'he1b00050, K_SHR},  '{32'he0b00000, K_ALU},
    '{32'he0d00000, K_ALU},  '{32'he1b00070, K_SHR},  '{32'he1100000, K_CMPR},
    '{32'he2700000, K_NEG},  '{32'he1500000, K_CMPR}, '{32'he1700000, K_CMPR},
    '{32'he1900000, K_ALU},  '{32'he0100090, K_MUL},  '{32'he1d00000, K_ALU},
    '{32'he1f00000, K_MVN},
    '{32'he0800000, K_HADD}, '{32'he1500000, K_HCMP}, '{32'he1a00000, K_HMOV},
    '{32'he12fff10, K_HBX},
    '{32'he7800000, K_DNM},  '{32'he18000b0, K_DNM},  '{32'he7c00000, K_DNM},
    '{32'he19000d0, K_DNM},  '{32'he7900000, K_DNM},  '{32'he19000b0, K_DNM},
    '{32'he7d00000, K_DNM},  '{32'he19000f0, K_DNM},  '{32'he0900000, K_DNM},
    '{32'he0500000, K_DNM},  '{32'he2900000, K_DNM},  '{32'he2500000, K_DNM},
    '{32'he5800000, K_W5},   '{32'he5900000, K_W5},   '{32'he5c00000, K_B5},
    '{32'he5d00000, K_B5},   '{32'he1c000b0, K_H5},   '{32'he1d000b0, K_H5},
    '{32'he1b00000, K_SH5},  '{32'he1b00020, K_SH5},  '{32'he1b00040, K_SH5},
    '{32'he3b00000, K_D8},   '{32'he3500000, K_C8},   '{32'he2900000, K_A8},
    '{32'he2500000, K_A8},   '{32'he59f0000, K_W8},   '{32'he58d0000, K_W8},
    '{32'he59d0000, K_W8},   '{32'he28f0f00, K_D8},   '{32'he28d0f00, K_D8},
    '{32'hef000000, K_SWI},
    '{32'he28ddf00, K_SP7},  '{32'he24ddf00, K_SP7},
    '{32'he92d0000, K_PUSH}, '{32'he8bd0000, K_POP},  '{32'he8a00000, K_STM},
    '{32'he8900000, K_LDM},
    '{32'h0a000000, K_BC},   '{32'hea000000, K_BR},
    '{UNDEF_WORD, K_NONE},   '{UNDEF_WORD, K_NONE},   '{UNDEF_WORD, K_NONE},
    '{UNDEF_WORD, K_NONE},   '{UNDEF_WORD, K_NONE}
  };

endpackage

[design/ctw_if.sv]
// Valid/ready channel interfaces for requests and results of the expander.
interface ctw_in_if;
  import ctw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [HALF_W-1:0] thumb_instr;

  modport source (output valid, output operation, output thumb_instr, input ready);
  modport sink (input valid, input operation, input thumb_instr, output ready);
endinterface

interface ctw_out_if;
  import ctw_pkg::*;
  logic              valid;
  logic              ready;
  logic [WIDE_W-1:0] wide_instr;

  modport source (output valid, output wide_instr, input ready);
  modport sink (input valid, input wide_instr, output ready);
endinterface

[design/ctw_expand.sv]
// Combinational translation of one halfword into its wide instruction word.
module ctw_expand
  import ctw_pkg::*;
(
  input  logic [OP_W-1:0]   operation,
  input  logic [HALF_W-1:0] thumb_instr,
  output logic [WIDE_W-1:0] wide_instr
);

  case_def_t         cdef;
  logic [WIDE_W-1:0] w, b0, b3, b6, b8, hd, hs, i5, i8, bit8;
  logic [WIDE_W-1:0] h5off, bc_off, br_off, cond;
  logic [7:0]        reg_list;
  logic              ldm_wb;

  assign cdef   = CASE_TABLE[operation];
  assign w      = cdef.tmpl;
  assign b0     = {29'd0, thumb_instr[2:0]};
  assign b3     = {29'd0, thumb_instr[5:3]};
  assign b6     = {29'd0, thumb_instr[8:6]};
  assign b8     = {29'd0, thumb_instr[10:8]};
  assign hd     = {28'd0, thumb_instr[7], thumb_instr[2:0]};
  assign hs     = {28'd0, thumb_instr[6:3]};
  assign i5     = {27'd0, thumb_instr[10:6]};
  assign i8     = {24'd0, thumb_instr[7:0]};
  assign bit8   = {31'd0, thumb_instr[8]};
  assign h5off  = {22'd0, thumb_instr[10:9], 4'd0, thumb_instr[8:6], 1'b0};
  assign cond   = {thumb_instr[11:8], 28'd0};
  assign bc_off = {8'd0, {16{thumb_instr[7]}}, thumb_instr[7:0]};
  assign br_off = {8'd0, {13{thumb_instr[10]}}, thumb_instr[10:0]};
  assign reg_list = thumb_instr[7:0];
  // Writeback only when the base register is not in the list.
  assign ldm_wb = ~reg_list[thumb_instr[10:8]];

  always_comb begin
    case (cdef.kind)
      K_ALU:   wide_instr = w | (b0 << 16) | (b0 << 12) | b3;
      K_SHR:   wide_instr = w | (b0 << 12) | (b3 << 8) | b0;
      K_CMPR:  wide_instr = w | (b0 << 16) | b3;
      K_NEG:   wide_instr = w | (b3 << 16) | (b0 << 12);
      K_MUL:   wide_instr = w | (b0 << 16) | (b0 << 8) | b3;
      K_MVN:   wide_instr = w | (b0 << 12) | b3;
      K_HADD:  wide_instr = w | (hd << 16) | (hd << 12) | hs;
      K_HCMP:  wide_instr = w | (hd << 16) | hs;
      K_HMOV:  wide_instr = w | (hd << 12) | hs;
      K_HBX:   wide_instr = w | hs;
      K_DNM:   wide_instr = w | (b3 << 16) | (b0 << 12) | b6;
      K_W5:    wide_instr = w | (b3 << 16) | (b0 << 12) | (i5 << 2);
      K_B5:    wide_instr = w | (b3 << 16) | (b0 << 12) | i5;
      K_H5:    wide_instr = w | (b3 << 16) | (b0 << 12) | h5off;
      K_SH5:   wide_instr = w | (b0 << 12) | (i5 << 7) | b3;
      K_D8:    wide_instr = w | (b8 << 12) | i8;
      K_C8:    wide_instr = w | (b8 << 16) | i8;
      K_A8:    wide_instr = w | (b8 << 16) | (b8 << 12) | i8;
      K_W8:    wide_instr = w | (b8 << 12) | (i8 << 2);
      K_SWI:   wide_instr = w | i8;
      K_SP7:   wide_instr = w | {25'd0, thumb_instr[6:0]};
      K_PUSH:  wide_instr = w | (bit8 << 14) | i8;
      K_POP:   wide_instr = w | (bit8 << 15) | i8;
      K_STM:   wide_instr = w | (b8 << 16) | i8;
      K_LDM:   wide_instr = w | {10'd0, ldm_wb, 21'd0} | (b8 << 16) | i8;
      K_BC:    wide_instr = cond | w | bc_off;
      K_BR:    wide_instr = w | br_off;
      default: wide_instr = UNDEF_WORD;
    endcase
  end

endmodule

[design/compact_to_wide_instruction_expander.sv]
// Top level: registered compact-to-wide instruction expander.
//
// Requests arrive on in_req (valid/ready) carrying a 6-bit translation
// selector and a 16-bit compact halfword. Each request yields exactly one
// 32-bit wide instruction word on out_res (valid/ready), in request order.
// A request is captured in an input register, expanded by a table lookup
// and field placement, and held in a result register.
// The result is shown on out_res once it has passed the input register and
// the result register. Throughput is one request per cycle while out_res.ready
// stays high; the input register and the result register form a two-entry pipeline.
// When the receiver stalls, the result register holds its word and the
// input register can still take one more request; in_req.ready drops only
// when both stages are full and out_res.ready is low.
// Synchronous active-low reset empties both stages; the data registers are not reset.
// Selectors above the last defined case give the permanently-undefined word.
module compact_to_wide_instruction_expander
  import ctw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  ctw_in_if.sink   in_req,
  ctw_out_if.source out_res
);

  logic              s1_vld_r, s1_vld_nxt;
  logic              s2_vld_r, s2_vld_nxt;
  logic [OP_W-1:0]   s1_op_r;
  logic [HALF_W-1:0] s1_instr_r;
  logic [WIDE_W-1:0] s2_word_r;
  logic [WIDE_W-1:0] exp_word;
  logic              s2_ready, s2_load, in_fire;

  assign s2_ready     = !s2_vld_r || out_res.ready;
  assign s2_load      = s1_vld_r && s2_ready;
  assign in_req.ready = !s1_vld_r || s2_ready;
  assign in_fire      = in_req.valid && in_req.ready;

  assign s1_vld_nxt = in_fire || (s1_vld_r && !s2_ready);
  assign s2_vld_nxt = s2_load || (s2_vld_r && !out_res.ready);

  ctw_expand u_expand (
    .operation   (s1_op_r),
    .thumb_instr (s1_instr_r),
    .wide_instr  (exp_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_req.operation;
      s1_instr_r <= in_req.thumb_instr;
    end
    if (s2_load) begin
      s2_word_r <= exp_word;
    end
  end

  assign out_res.valid      = s2_vld_r;
  assign out_res.wide_instr = s2_word_r;

endmodule

[design/ctw_checker.sv]
// Port-level checker for the instruction expander, bound to the top level.
`include "compact_to_wide_instruction_expander_defines.svh"

module ctw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_wide_instr
);

  // A result that is not taken stays on the port unchanged.
  `CTW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_wide_instr))

  // The block only backs up when both stages are full and the receiver stalls.
  `CTW_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready)

  // A fresh result follows a request that was accepted and passed through both stages.
  `CTW_ASSERT_NOW(a_out_origin, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind compact_to_wide_instruction_expander ctw_checker u_ctw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_wide_instr (out_res.wide_instr)
);

[verif/compact_op_pkg.sv]
// Translation selector codes shared by the expander checker and its testbench.
package compact_op_pkg;

  typedef enum logic [5:0] {
    OP_AND = 6'd0, OP_EOR, OP_LSL, OP_LSR, OP_ASR, OP_ADC, OP_SBC, OP_ROR, OP_TST,
    OP_NEG, OP_CMP, OP_CMN, OP_ORR, OP_MUL, OP_BIC, OP_MVN,
    OP_ADD_HI, OP_CMP_HI, OP_MOV_HI, OP_BX,
    OP_STR_REG, OP_STRH_REG, OP_STRB_REG, OP_LDRSB_REG, OP_LDR_REG,
    OP_LDRH_REG, OP_LDRB_REG, OP_LDRSH_REG, OP_ADD_REG, OP_SUB_REG,
    OP_ADD_IMM3, OP_SUB_IMM3, OP_STR_IMM5, OP_LDR_IMM5, OP_STRB_IMM5,
    OP_LDRB_IMM5, OP_STRH_IMM5, OP_LDRH_IMM5,
    OP_LSL_IMM5, OP_LSR_IMM5, OP_ASR_IMM5,
    OP_MOV_IMM8, OP_CMP_IMM8, OP_ADD_IMM8, OP_SUB_IMM8, OP_LDR_PC,
    OP_STR_SP, OP_LDR_SP, OP_ADR_PC, OP_ADR_SP, OP_SWI, OP_ADD_SP, OP_SUB_SP,
    OP_PUSH, OP_POP, OP_STMIA, OP_LDMIA, OP_BCOND, OP_B, OP_UNDEF
  } compact_op_e;

  // Highest selector value the 6-bit field can carry.
  localparam logic [5:0] OP_MAX = 6'd63;

endpackage

[verif/expansion_checker.sv]
// Checker that predicts each expanded wide instruction and compares it with the block output.
module expansion_checker
  import ctw_pkg::*;
  import compact_op_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ctw_in_if    req_ch,
  ctw_out_if   res_ch,
  output int   fail_count,
  output int   outstanding
);

  typedef struct {
    logic [5:0]  op;
    logic [15:0] half;
    logic [31:0] word;
  } due_word_t;

  due_word_t words_due[$];
  due_word_t head;
  int        errors;

  function automatic logic [31:0] expand_halfword(logic [5:0] sel, logic [15:0] h);
    case_def_t   entry;
    logic [31:0] b0, b3, b6, b8, hd, hs, i5, i8, word;
    logic [7:0]  rlist;
    b0 = {29'd0, h[2:0]};
    b3 = {29'd0, h[5:3]};
    b6 = {29'd0, h[8:6]};
    b8 = {29'd0, h[10:8]};
    hd = {28'd0, h[7], h[2:0]};
    hs = {28'd0, h[6:3]};
    i5 = {27'd0, h[10:6]};
    i8 = {24'd0, h[7:0]};
    rlist = h[7:0];
    case (sel)
      OP_AND:       entry = '{32'he0100000, K_ALU};
      OP_EOR:       entry = '{32'he0300000, K_ALU};
      OP_LSL:       entry = '{32'he1b00010, K_SHR};
      OP_LSR:       entry = '{32'he1b00030, K_SHR};
      OP_ASR:       entry = '{32'he1b00050, K_SHR};
      OP_ADC:       entry = '{32'he0b00000, K_ALU};
      OP_SBC:       entry = '{32'he0d00000, K_ALU};
      OP_ROR:       entry = '{32'he1b00070, K_SHR};
      OP_TST:       entry = '{32'he1100000, K_CMPR};
      OP_NEG:       entry = '{32'he2700000, K_NEG};
      OP_CMP:       entry = '{32'he1500000, K_CMPR};
      OP_CMN:       entry = '{32'he1700000, K_CMPR};
      OP_ORR:       entry = '{32'he1900000, K_ALU};
      OP_MUL:       entry = '{32'he0100090, K_MUL};
      OP_BIC:       entry = '{32'he1d00000, K_ALU};
      OP_MVN:       entry = '{32'he1f00000, K_MVN};
      OP_ADD_HI:    entry = '{32'he0800000, K_HADD};
      OP_CMP_HI:    entry = '{32'he1500000, K_HCMP};
      OP_MOV_HI:    entry = '{32'he1a00000, K_HMOV};
      OP_BX:        entry = '{32'he12fff10, K_HBX};
      OP_STR_REG:   entry = '{32'he7800000, K_DNM};
      OP_STRH_REG:  entry = '{32'he18000b0, K_DNM};
      OP_STRB_REG:  entry = '{32'he7c00000, K_DNM};
      OP_LDRSB_REG: entry = '{32'he19000d0, K_DNM};
      OP_LDR_REG:   entry = '{32'he7900000, K_DNM};
      OP_LDRH_REG:  entry = '{32'he19000b0, K_DNM};
      OP_LDRB_REG:  entry = '{32'he7d00000, K_DNM};
      OP_LDRSH_REG: entry = '{32'he19000f0, K_DNM};
      OP_ADD_REG:   entry = '{32'he0900000, K_DNM};
      OP_SUB_REG:   entry = '{32'he0500000, K_DNM};
      OP_ADD_IMM3:  entry = '{32'he2900000, K_DNM};
      OP_SUB_IMM3:  entry = '{32'he2500000, K_DNM};
      OP_STR_IMM5:  entry = '{32'he5800000, K_W5};
      OP_LDR_IMM5:  entry = '{32'he5900000, K_W5};
      OP_STRB_IMM5: entry = '{32'he5c00000, K_B5};
      OP_LDRB_IMM5: entry = '{32'he5d00000, K_B5};
      OP_STRH_IMM5: entry = '{32'he1c000b0, K_H5};
      OP_LDRH_IMM5: entry = '{32'he1d000b0, K_H5};
      OP_LSL_IMM5:  entry = '{32'he1b00000, K_SH5};
      OP_LSR_IMM5:  entry = '{32'he1b00020, K_SH5};
      OP_ASR_IMM5:  entry = '{32'he1b00040, K_SH5};
      OP_MOV_IMM8:  entry = '{32'he3b00000, K_D8};
      OP_CMP_IMM8:  entry = '{32'he3500000, K_C8};
      OP_ADD_IMM8:  entry = '{32'he2900000, K_A8};
      OP_SUB_IMM8:  entry = '{32'he2500000, K_A8};
      OP_LDR_PC:    entry = '{32'he59f0000, K_W8};
      OP_STR_SP:    entry = '{32'he58d0000, K_W8};
      OP_LDR_SP:    entry = '{32'he59d0000, K_W8};
      OP_ADR_PC:    entry = '{32'he28f0f00, K_D8};
      OP_ADR_SP:    entry = '{32'he28d0f00, K_D8};
      OP_SWI:       entry = '{32'hef000000, K_SWI};
      OP_ADD_SP:    entry = '{32'he28ddf00, K_SP7};
      OP_SUB_SP:    entry = '{32'he24ddf00, K_SP7};
      OP_PUSH:      entry = '{32'he92d0000, K_PUSH};
      OP_POP:       entry = '{32'he8bd0000, K_POP};
      OP_STMIA:     entry = '{32'he8a00000, K_STM};
      OP_LDMIA:     entry = '{32'he8900000, K_LDM};
      OP_BCOND:     entry = '{32'h0a000000, K_BC};
      OP_B:         entry = '{32'hea000000, K_BR};
      default:      entry = '{UNDEF_WORD, K_NONE};
    endcase
    word = entry.tmpl;
    case (entry.kind)
      K_ALU:  word = word | (b0 << 16) | (b0 << 12) | b3;
      K_SHR:  word = word | (b0 << 12) | (b3 << 8) | b0;
      K_CMPR: word = word | (b0 << 16) | b3;
      K_NEG:  word = word | (b3 << 16) | (b0 << 12);
      K_MUL:  word = word | (b0 << 16) | (b0 << 8) | b3;
      K_MVN:  word = word | (b0 << 12) | b3;
      K_HADD: word = word | (hd << 16) | (hd << 12) | hs;
      K_HCMP: word = word | (hd << 16) | hs;
      K_HMOV: word = word | (hd << 12) | hs;
      K_HBX:  word = word | hs;
      K_DNM:  word = word | (b3 << 16) | (b0 << 12) | b6;
      K_W5:   word = word | (b3 << 16) | (b0 << 12) | (i5 << 2);
      K_B5:   word = word | (b3 << 16) | (b0 << 12) | i5;
      // The halfword byte offset is split into a high and a low nibble.
      K_H5:   word = word | (b3 << 16) | (b0 << 12) | {22'd0, h[10:9], 8'd0} | (b6 << 1);
      K_SH5:  word = word | (b0 << 12) | (i5 << 7) | b3;
      K_D8:   word = word | (b8 << 12) | i8;
      K_C8:   word = word | (b8 << 16) | i8;
      K_A8:   word = word | (b8 << 16) | (b8 << 12) | i8;
      K_W8:   word = word | (b8 << 12) | (i8 << 2);
      K_SWI:  word = word | i8;
      K_SP7:  word = word | {25'd0, h[6:0]};
      K_PUSH: word = word | {17'd0, h[8], 14'd0} | i8;
      K_POP:  word = word | {16'd0, h[8], 15'd0} | i8;
      K_STM:  word = word | (b8 << 16) | i8;
      // Writeback only when the base register is missing from the list.
      K_LDM:  word = word | {10'd0, ~rlist[h[10:8]], 21'd0} | (b8 << 16) | i8;
      K_BC:   word = {h[11:8], 28'd0} | word | {8'd0, {16{h[7]}}, h[7:0]};
      K_BR:   word = word | {8'd0, {13{h[10]}}, h[10:0]};
      default: word = UNDEF_WORD;
    endcase
    return word;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      words_due.delete();
      errors = 0;
      outstanding <= 0;
      fail_count  <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        words_due.push_back('{req_ch.operation, req_ch.thumb_instr,
                              expand_halfword(req_ch.operation, req_ch.thumb_instr)});
      if (res_ch.valid && res_ch.ready) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected wide_instr: expected none, got %h", $time,
                   res_ch.wide_instr);
          errors++;
        end else begin
          head = words_due.pop_front();
          if (res_ch.wide_instr !== head.word) begin
            $display("%0t: wide_instr mismatch (op %0d, halfword %h): expected %h, got %h",
                     $time, head.op, head.half, head.word, res_ch.wide_instr);
            errors++;
          end
        end
      end
      outstanding <= words_due.size();
      fail_count  <= errors;
    end
  end

endmodule

[verif/tb_compact_to_wide_instruction_expander.sv]
// Testbench top: drives requests and result backpressure into the expander and reports the verdict.
module tb_compact_to_wide_instruction_expander;
  import ctw_pkg::*;
  import compact_op_pkg::*;

  localparam int RANDOM_ITEMS     = 760;
  localparam int LONG_HOLD_CYCLES = 40;
  localparam int DRAIN_CYCLES     = 8;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   hold_reqs;
  logic calm;

  ctw_in_if  req_ch();
  ctw_out_if res_ch();

  compact_to_wide_instruction_expander i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  expansion_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ch      (req_ch),
    .res_ch      (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_request(input logic [5:0] op, input logic [15:0] half);
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= op;
    req_ch.thumb_instr <= half;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Sends one request, then sometimes leaves a gap before the next one.
  task automatic offer(input logic [5:0] op, input logic [15:0] half, input bit allow_gap);
    send_request(op, half);
    if (allow_gap && !calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side backpressure, with an occasional long hold-off on request.
  initial begin
    int holds_served;
    holds_served = 0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_reqs != holds_served) begin
        holds_served++;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [5:0] op;
    bit         gaps;
    rst_n              <= 1'b0;
    hold_reqs          <= 0;
    calm               <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_AND;
    req_ch.thumb_instr <= 16'h0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes and the special encodings.
    offer(OP_AND, 16'h0000, 1'b1);
    offer(OP_AND, 16'hffff, 1'b1);
    offer(OP_MAX, 16'hffff, 1'b1);
    offer(OP_UNDEF, 16'h0000, 1'b1);
    offer(OP_ADD_HI, 16'h00ff, 1'b1);
    offer(OP_MOV_HI, 16'h0080, 1'b1);
    offer(OP_BX, 16'h0078, 1'b1);
    offer(OP_STRH_IMM5, 16'h07c0, 1'b1);
    offer(OP_LDRH_IMM5, 16'h0440, 1'b1);
    offer(OP_LDR_IMM5, 16'h07ff, 1'b1);
    offer(OP_LDR_PC, 16'h07ff, 1'b1);
    offer(OP_ADR_SP, 16'h07ff, 1'b1);
    offer(OP_SUB_SP, 16'h007f, 1'b1);
    offer(OP_PUSH, 16'h01ff, 1'b1);
    offer(OP_PUSH, 16'h00a5, 1'b1);
    offer(OP_POP, 16'h0100, 1'b1);
    offer(OP_POP, 16'h00ff, 1'b1);
    offer(OP_LDMIA, 16'h0304, 1'b1);
    offer(OP_LDMIA, 16'h0308, 1'b1);
    offer(OP_BCOND, 16'h0e80, 1'b1);
    offer(OP_BCOND, 16'h0f7f, 1'b1);
    offer(OP_BCOND, 16'h0080, 1'b1);
    offer(OP_B, 16'h0400, 1'b1);
    offer(OP_B, 16'h03ff, 1'b1);
    offer(OP_LSL_IMM5, 16'h07ff, 1'b1);

    // Every selector once with random content.
    for (int k = OP_AND; k <= OP_MAX; k++)
      offer(k[5:0], 16'($urandom_range(0, 65535)), 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200)
        hold_reqs <= hold_reqs + 1;
      if (n == 400)
        wait_drained();
      if (n == 660)
        calm <= 1'b1;
      // Keep offering back to back while the result side is held off.
      gaps = !(n >= 200 && n < 240);
      if ($urandom_range(0, 9) == 0)
        op = 6'($urandom_range(OP_UNDEF, OP_MAX));
      else
        op = 6'($urandom_range(OP_AND, OP_B));
      offer(op, 16'($urandom_range(0, 65535)), gaps);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
